/* design/tcd_pkg.sv */
package tcd_pkg;

   localparam int SAMPLE_W = 16;
   localparam int MEAN_W   = 25;   // Q16.8 signed
   localparam int RATE_W   = 17;   // Q1.16, 65536 = 1.0
   localparam int DEV_W    = 16;
   localparam int AXIS_W   = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 17;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DEV_THR  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RATE_THR = 1'd1;

   localparam logic [15:0] DEV_THR_RESET  = 16'd1000;
   localparam logic [16:0] RATE_THR_RESET = 17'd32768;

   // averaging weights
   localparam int MEAN_KEEP = 49;
   localparam int RATE_KEEP = 9;

   // floor(x/25) = (x * DIV25_MUL) >> DIV25_SHIFT, exact for x < 2^30
   localparam logic [28:0] DIV25_MUL   = 29'd343597384;
   localparam int          DIV25_SHIFT = 33;
   // floor(x/5) = (x * DIV5_MUL) >> DIV5_SHIFT, exact for x < 699050
   localparam logic [18:0] DIV5_MUL    = 19'd419431;
   localparam int          DIV5_SHIFT  = 21;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [MEAN_W-1:0]   mean_type;
   typedef logic [RATE_W-1:0]          rate_type;
   typedef logic [DEV_W-1:0]           dev_type;

   typedef struct packed {
      mean_type mean;
      rate_type rate;
   } axis_state_type;

   typedef struct packed {
      logic    touch;
      logic    collide;
      dev_type deviation;
   } result_type;

endpackage

/* design/tcd_math.sv */
module tcd_math (
   input  tcd_pkg::sample_type     sample,
   input  tcd_pkg::axis_state_type cur,
   input  tcd_pkg::dev_type        dev_thr,
   input  tcd_pkg::rate_type       rate_thr,
   output tcd_pkg::result_type     result,
   output tcd_pkg::axis_state_type nxt
);
   import tcd_pkg::*;

   logic signed [23:0] sample_q;
   logic signed [25:0] diff;
   logic [24:0]        mag;
   logic [16:0]        dev_raw;
   logic               touch;

   logic signed [29:0] mean_num;
   logic               mean_neg;
   logic [28:0]        mean_mag;
   logic [56:0]        mean_prod;
   logic [23:0]        mean_q;

   logic [19:0]        rate_num;
   logic [37:0]        rate_prod;

   always_comb begin
      sample_q = {sample, 8'h00};
      diff     = 26'(sample_q) - 26'(cur.mean);
      mag      = diff[25] ? 25'(-diff) : 25'(diff);
      touch    = mag > 25'({dev_thr, 8'h00});
      dev_raw  = mag[24:8];

      result.touch     = touch;
      result.collide   = touch && (cur.rate > rate_thr);
      result.deviation = dev_raw[16] ? '1 : dev_raw[15:0];

      // (256*sample + 49*mean) / 50, truncated toward zero: halve, then /25
      mean_num  = 30'(sample_q) + 30'(cur.mean) * 30'(signed'(MEAN_KEEP));
      mean_neg  = mean_num[29];
      mean_mag  = mean_neg ? 29'(-mean_num) : 29'(mean_num);
      mean_prod = 57'(mean_mag[28:1]) * 57'(DIV25_MUL);
      mean_q    = mean_prod[DIV25_SHIFT +: 24];
      nxt.mean  = mean_neg ? -mean_type'(mean_q) : mean_type'(mean_q);

      // (65536*touch + 9*rate) / 10: halve, then /5
      rate_num  = (touch ? 20'd65536 : 20'd0) + 20'(cur.rate) * 20'(RATE_KEEP);
      rate_prod = 38'(rate_num[19:1]) * 38'(DIV5_MUL);
      nxt.rate  = rate_prod[DIV5_SHIFT +: RATE_W];
   end

endmodule

/* design/tcd_state.sv */
module tcd_state #(
   parameter int AXES = 3,
   parameter int IDX_W = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [IDX_W-1:0]        rd_idx,
   input  logic                    upd_en,
   input  tcd_pkg::axis_state_type upd_val,
   output tcd_pkg::axis_state_type rd_val
);
   import tcd_pkg::*;

   axis_state_type state_ff [AXES];

   assign rd_val = state_ff[rd_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            state_ff[i] <= '0;
         end
      end else if (upd_en) begin
         state_ff[rd_idx] <= upd_val;
      end
   end

endmodule

/* design/torque_collision_detector.sv */
// Channel  | Dir | Fields (low bit first)
// ---------+-----+-------------------------------------------------------------
// req_     | in  | tuser: axis_index[1:0]; tdata: torque_sample[15:0]
// rsp_     | out | tdata: touch_flag[0], collision_flag[1], deviation[17:2], pad
// csr_     | in  | csr_index 0: deviation_threshold, 1: rate_threshold
//
// One word per cycle sustained while rsp_tready holds high; a taken word passes the input
// register, then the result register, which drives rsp_.
// Per-axis averages are read and rewritten in the same cycle the word moves into
// the result register, so back to back words on one axis see the fresh average.
// Reset is synchronous: clears both averages of every axis and loads the
// threshold defaults. A stalled rsp_ holds its word; req_ keeps taking one more.
module torque_collision_detector #(
   parameter int AXES = 3
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [16:0] csr_wdata,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // torque_sample[15:0]
   input  logic [1:0]  req_tuser,   // axis_index[1:0]

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // touch_flag, collision_flag, deviation[15:0], 6'b0
);
   import tcd_pkg::*;

   localparam int IDX_W = (AXES > 1) ? $clog2(AXES) : 1;

   // thresholds
   dev_type  dev_thr_ff;
   rate_type rate_thr_ff;

   // input stage
   logic              in_valid_ff;
   logic [AXIS_W-1:0] in_axis_ff;
   sample_type        in_sample_ff;

   // result stage
   logic       out_valid_ff;
   result_type out_ff, out_in;

   logic           advance;
   logic           axis_ok;
   logic [IDX_W-1:0] idx;
   axis_state_type cur_state, nxt_state;
   result_type     calc;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_thr_ff  <= DEV_THR_RESET;
         rate_thr_ff <= RATE_THR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_DEV_THR:  dev_thr_ff  <= csr_wdata[15:0];
            REG_RATE_THR: rate_thr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register moves on when the result register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_axis_ff   <= req_tuser;
         in_sample_ff <= req_tdata;
      end
   end

   // axes beyond AXES touch no state and report all zeros
   assign axis_ok = 32'(in_axis_ff) < AXES;
   assign idx     = IDX_W'(in_axis_ff);

   tcd_state #(
      .AXES  (AXES),
      .IDX_W (IDX_W)
   ) u_state (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (idx),
      .upd_en  (advance && axis_ok),
      .upd_val (nxt_state),
      .rd_val  (cur_state)
   );

   tcd_math u_math (
      .sample   (in_sample_ff),
      .cur      (cur_state),
      .dev_thr  (dev_thr_ff),
      .rate_thr (rate_thr_ff),
      .result   (calc),
      .nxt      (nxt_state)
   );

   assign out_in = axis_ok ? calc : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_ff.deviation, out_ff.collide, out_ff.touch};

endmodule

/* tb/sv/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tcd_pkg::*;

   localparam int AXES_N = 3;

   // ---------------------------------------------------------------------------
   // Expected-result book: mirrors the per-axis averages and the thresholds,
   // predicts one result word per accepted sample word, checks rsp_ words in order.
   // ---------------------------------------------------------------------------
   class collision_scoreboard;
      logic [15:0] dev_thr;
      rate_type    rate_thr;
      mean_type    mean_q [AXES_N];
      rate_type    rate_q [AXES_N];
      result_type  expected_results [$];
      int unsigned failures;

      function new();
         dev_thr  = DEV_THR_RESET;
         rate_thr = RATE_THR_RESET;
         foreach (mean_q[i]) begin
            mean_q[i] = '0;
            rate_q[i] = '0;
         end
         failures = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_DEV_THR:  dev_thr  = value[15:0];   // upper bit dropped
            REG_RATE_THR: rate_thr = value;
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return expected_results.size();
      endfunction

      // predict the result of one accepted sample word and advance the averages
      function void note_sample(logic [1:0] axis, logic [15:0] raw);
         result_type want;
         longint     smp, avg, diff, mag, dev;
         longint     rate_old;
         logic       touch;
         want = '0;
         if (axis < AXES_N) begin
            smp      = longint'(sample_type'(raw));
            avg      = longint'(mean_q[axis]);
            rate_old = longint'(rate_q[axis]);
            diff     = smp * 256 - avg;
            mag      = (diff < 0) ? -diff : diff;
            touch    = mag > longint'(dev_thr) * 256;
            dev      = mag / 256;
            if (dev > 65535) dev = 65535;
            want.touch     = touch;
            want.collide   = touch && (rate_old > longint'(rate_thr));
            want.deviation = dev_type'(dev);
            // signed division truncates toward zero, as the block does
            mean_q[axis] = mean_type'((smp * 256 + MEAN_KEEP * avg) / 50);
            rate_q[axis] = rate_type'(((touch ? 65536 : 0) + RATE_KEEP * rate_old) / 10);
         end
         expected_results.push_back(want);
      endfunction

      function void check_result(logic [23:0] word);
         result_type want;
         logic       touch, coll;
         dev_type    dev;
         touch = word[0];
         coll  = word[1];
         dev   = word[17:2];
         if (expected_results.size() == 0) begin
            failures++;
            if (failures <= 10) $display("rsp word %h arrived with nothing outstanding", word);
            return;
         end
         want = expected_results.pop_front();
         if (touch !== want.touch || coll !== want.collide || dev !== want.deviation) begin
            failures++;
            if (failures <= 10)
               $display("mismatch: expected touch %b collision %b deviation %0d, got %b %b %0d",
                        want.touch, want.collide, want.deviation, touch, coll, dev);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [16:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // torque_sample[15:0]
   logic [1:0]  req_tuser;    // axis_index[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;    // touch_flag[0], collision_flag[1], deviation[17:2], pad

   collision_scoreboard book = new();

   // no-idle stretch counters, one per side
   int unsigned req_calm = 0;
   int unsigned rsp_calm = 0;

   // per-axis torque level used by the steady-signal bursts
   int level_of [AXES_N];

   torque_collision_detector #(
      .AXES (AXES_N)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Idle length: mostly none, some short, a few long; now and then a run
   // of several dozen calls with no idling at all.
   function automatic int unsigned gap_len(inout int unsigned calm);
      int unsigned r;
      if (calm != 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 62) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] to_sample(int v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   // Offer one sample word, note it at the accepting edge, then maybe idle.
   // valid stays high across back-to-back words (no lower/raise in one step).
   task automatic send_word(input logic [1:0] axis, input logic [15:0] sample);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= axis;
      req_tdata  <= sample;
      do @(posedge clock); while (!req_tready);
      book.note_sample(axis, sample);
      gap = gap_len(req_calm);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending until every expected word is back, then let the pipe settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Both thresholds in back-to-back write cycles; only call with the block idle.
   task automatic write_thresholds(input logic [16:0] dev_value, input logic [16:0] rate_value);
      csr_we    <= 1'b1;
      csr_index <= REG_DEV_THR;
      csr_wdata <= dev_value;
      @(posedge clock);
      book.set_register(REG_DEV_THR, dev_value);
      csr_index <= REG_RATE_THR;
      csr_wdata <= rate_value;
      @(posedge clock);
      book.set_register(REG_RATE_THR, rate_value);
      csr_we <= 1'b0;
   endtask

   // Directed words on reset thresholds: exact threshold edge, fresh-axis touch,
   // out-of-range axis at both sample extremes, a long touch streak that drives
   // the rate average over its threshold, then zero samples.
   task automatic run_directed();
      send_word(2'd2, to_sample(1000));     // |diff| == threshold: no touch
      send_word(2'd1, to_sample(-1001));    // just over: touch, rate still 0
      send_word(2'd3, 16'h7FFF);            // axis out of range: all-zero result
      send_word(2'd3, 16'h8000);
      for (int k = 0; k < 16; k++)
         send_word(2'd0, (k % 2 == 0) ? 16'h7FFF : 16'h8000);
      send_word(2'd1, 16'h0000);
      send_word(2'd2, 16'h0000);
      send_word(2'd0, 16'h0000);
   endtask

   // Random words in bursts: mostly steady per-axis signals with noise around
   // the deviation threshold, plus swings that build touch streaks, extremes,
   // out-of-range axes and plain noise. One drain pause lands mid-phase.
   task automatic run_random(input int unsigned count);
      int unsigned sent, burst, kind, pause_at;
      int          amp, swing, thr;
      logic [1:0]  axis;
      logic [15:0] smp;
      sent     = 0;
      pause_at = $urandom_range(10, count - 10);
      while (sent < count) begin
         kind  = $urandom_range(0, 9);
         burst = $urandom_range(8, 40);
         axis  = 2'($urandom_range(0, AXES_N - 1));
         thr   = int'(book.dev_thr);
         amp   = thr + thr / 2 + 1;
         swing = thr + int'($urandom_range(1, 4000));
         if ($urandom_range(0, 9) < 3) level_of[axis] = int'($urandom_range(0, 65535)) - 32768;
         for (int k = 0; k < burst && sent < count; k++) begin
            if (sent == pause_at) drain();
            case (kind)
               0, 1: begin
                  axis = 2'($urandom_range(0, 3));
                  smp  = 16'($urandom_range(0, 65535));
               end
               2, 3, 4, 5: begin
                  axis = 2'($urandom_range(0, AXES_N - 1));
                  smp  = to_sample(level_of[axis] + int'($urandom_range(0, 2 * amp)) - amp);
               end
               6, 7: begin
                  smp = to_sample(level_of[axis] + ((k % 2 == 0) ? swing : -swing));
               end
               8: begin
                  axis = ($urandom_range(0, 3) == 0) ? 2'd3 : 2'($urandom_range(0, AXES_N - 1));
                  smp  = to_sample(level_of[axis] + int'($urandom_range(0, 2 * amp)) - amp);
               end
               default: begin
                  axis = 2'($urandom_range(0, 3));
                  case ($urandom_range(0, 3))
                     0:       smp = 16'h7FFF;
                     1:       smp = 16'h8000;
                     2:       smp = 16'h0000;
                     default: smp = 16'hFFFF;
                  endcase
               end
            endcase
            send_word(axis, smp);
            sent++;
         end
      end
   endtask

   // Result side: random backpressure, checked at each accepting edge.
   initial begin : rsp_side
      int unsigned stall;
      stall      = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall == 0) stall = gap_len(rsp_calm);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) book.check_result(rsp_tdata);
   end

   // Main sequence: reset, directed words, then phases of random words, each
   // phase under new thresholds written while the block is idle.
   initial begin
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = REG_DEV_THR;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      foreach (level_of[i]) level_of[i] = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_random(255);
      drain();

      // every nonzero difference touches; a touch with any nonzero rate collides
      write_thresholds(17'd0, 17'd0);
      run_random(255);
      drain();

      // written value wider than the register; rate can never reach 1.0
      write_thresholds(17'h1FFFF, 17'd65536);
      run_random(255);
      drain();

      // small threshold, top bit set at random; rate threshold at full width
      write_thresholds({1'($urandom_range(0, 1)), 16'($urandom_range(0, 3000))}, 17'h1FFFF);
      run_random(255);
      drain();

      write_thresholds(17'($urandom_range(500, 2000)), 17'($urandom_range(0, 65536)));
      run_random(255);
      drain();

      write_thresholds(17'($urandom_range(0, 131071)), 17'($urandom_range(0, 131071)));
      run_random(255);
      drain();

      repeat (10) @(posedge clock);
      if (book.failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog: far above the slowest legal run.
   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* sim.f */
design/tcd_pkg.sv
design/tcd_math.sv
design/tcd_state.sv
design/torque_collision_detector.sv
tb/sv/testbench.sv
